// File: rtl/core/scrr_pkg.sv
// shared types, constants and sample decoder for the stereo capture resample ring
`timescale 1ns / 1ps

package scrr_pkg;

    localparam int RING_FRAMES_DEF = 4096;
    localparam int READ_MAX_DEF    = 64;

    localparam int SAMPLE_W   = 24;
    localparam int CNT_W      = 7;
    localparam int STEP_W     = 20;
    localparam int PHASE_W    = 21;
    localparam int DROP_W     = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 20;

    localparam logic [PHASE_W-1:0] PHASE_ONE = PHASE_W'(65536);
    localparam logic [STEP_W-1:0]  STEP_RST  = STEP_W'(65536);
    localparam logic [DROP_W-1:0]  DROP_MAX  = '1;

    localparam logic signed [SAMPLE_W-1:0] Q23_MAX = 24'sh7FFFFF;
    localparam logic signed [SAMPLE_W-1:0] Q23_MIN = 24'sh800000;

    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_FORMAT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STEREO_INPUT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RATE_STEP     = 2'd2;

    localparam logic [1:0] FMT_INT16   = 2'd0;
    localparam logic [1:0] FMT_INT24   = 2'd1;
    localparam logic [1:0] FMT_INT32   = 2'd2;
    localparam logic [1:0] FMT_FLOAT32 = 2'd3;

    localparam logic KIND_SOURCE = 1'b0;
    localparam logic KIND_READ   = 1'b1;

    typedef struct packed {
        logic             kind;
        logic [31:0]      left_raw;
        logic [31:0]      right_raw;
        logic             silent;
        logic [CNT_W-1:0] read_count;
    } in_item_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] left_sample;
        logic signed [SAMPLE_W-1:0] right_sample;
        logic                       is_padding;
        logic                       last;
        logic [DROP_W-1:0]          drop_count;
    } out_item_t;

    typedef struct packed {
        logic capture;
        logic decode;
        logic rd_setup;
        logic write_frame;
        logic phase_wrap;
        logic emit_pad;
        logic rd_issue;
        logic rd_load;
    } cmd_t;

    typedef struct packed {
        logic is_read;
        logic want_zero;
        logic phase_low;
        logic pad_pending;
        logic beats_one;
        logic out_free;
    } sts_t;

    function automatic logic signed [SAMPLE_W-1:0] decode_word(input logic [31:0] raw,
                                                             input logic [1:0] fmt);
        logic [7:0]                 expo;
        logic [7:0]                 shift;
        logic [SAMPLE_W-1:0]        mag;
        logic signed [SAMPLE_W-1:0] res;
        expo  = raw[30:23];
        shift = 8'd127 - expo;
        mag   = '0;
        res   = '0;
        unique case (fmt)
            FMT_INT16: res = {raw[15:0], 8'h00};
            FMT_INT24: res = raw[23:0];
            FMT_INT32: res = raw[31:8];
            FMT_FLOAT32: begin
                if (expo == 8'hFF && raw[22:0] != 23'd0) begin
                    res = '0;
                end else if (expo >= 8'd127) begin
                    res = raw[31] ? Q23_MIN : Q23_MAX;
                end else if (expo == 8'd0) begin
                    res = '0;
                end else begin
                    mag = (shift >= 8'd24) ? '0 : ({1'b1, raw[22:0]} >> shift);
                    res = raw[31] ? -mag : mag;
                end
            end
        endcase
        return res;
    endfunction

endpackage

// File: rtl/core/stereo_capture_resample_ring.sv
// top level of the stereo capture resample ring
//
//   port group   dir   handshake            beat
//   s_*          in    s_valid / s_ready    source frame or read request
//   m_*          out   m_valid / m_ready    one output frame
//   cfg_*        in    cfg_we               register write, no wait
//
// a source frame is captured and decoded, then the phase accumulator writes n frames
// and wraps (one ring memory write per cycle; n reaches 65536 at the smallest step)
// a read request sends its padding beats, then reads and loads each stored frame
// (single ring read port, registered read data)
// synchronous active-low reset clears control state; the ring contents are not cleared
// a stalled m_ready holds the sequencer before its next beat; s_ready is high when idle
`timescale 1ns / 1ps

module stereo_capture_resample_ring
    import scrr_pkg::*;
#(
    parameter int RING_FRAMES = RING_FRAMES_DEF,
    parameter int READ_MAX    = READ_MAX_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  in_item_t              s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output out_item_t             m_data
);

    cmd_t cmd;
    sts_t sts;

    scrr_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    scrr_dp #(
        .RING_FRAMES (RING_FRAMES),
        .READ_MAX    (READ_MAX)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cmd       (cmd),
        .sts       (sts)
    );

`ifndef SYNTHESIS
    a_load_after_issue: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.rd_load |-> $past(cmd.rd_issue))
        else $error("ring data loaded without a preceding read");

    a_beat_needs_room: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.emit_pad || cmd.rd_issue) |-> sts.out_free)
        else $error("beat started while output register is occupied");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input taken again before the previous item was dispatched");

    a_no_write_during_read: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.write_frame |-> !(cmd.rd_issue || cmd.emit_pad || cmd.rd_load))
        else $error("ring write overlaps a read burst");
`endif

endmodule

// File: rtl/core/scrr_ctrl.sv
// controller state machine for the stereo capture resample ring
`timescale 1ns / 1ps

module scrr_ctrl
    import scrr_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  sts_t sts,
    output cmd_t cmd
);

    typedef enum logic [5:0] {
        ST_IDLE     = 6'b000001,
        ST_DISPATCH = 6'b000010,
        ST_WRITE    = 6'b000100,
        ST_RD_RUN   = 6'b001000,
        ST_RD_LOAD  = 6'b010000,
        ST_UNUSED   = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                if (sts.is_read) begin
                    if (sts.want_zero) begin
                        state_next = ST_IDLE;
                    end else begin
                        cmd.rd_setup = 1'b1;
                        state_next   = ST_RD_RUN;
                    end
                end else begin
                    cmd.decode = 1'b1;
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE: begin
                if (sts.phase_low) begin
                    cmd.write_frame = 1'b1;
                end else begin
                    cmd.phase_wrap = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            ST_RD_RUN: begin
                if (sts.out_free) begin
                    if (sts.pad_pending) begin
                        cmd.emit_pad = 1'b1;
                        if (sts.beats_one) begin
                            state_next = ST_IDLE;
                        end
                    end else begin
                        cmd.rd_issue = 1'b1;
                        state_next   = ST_RD_LOAD;
                    end
                end
            end
            ST_RD_LOAD: begin
                cmd.rd_load = 1'b1;
                state_next  = sts.beats_one ? ST_IDLE : ST_RD_RUN;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/core/scrr_dp.sv
// datapath: config registers, decoder, phase accumulator, ring memory and output register
`timescale 1ns / 1ps

module scrr_dp
    import scrr_pkg::*;
#(
    parameter int RING_FRAMES = RING_FRAMES_DEF,
    parameter int READ_MAX    = READ_MAX_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  in_item_t              s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output out_item_t             m_data,
    input  cmd_t                  cmd,
    output sts_t                  sts
);

    localparam int IDX_W  = $clog2(RING_FRAMES);
    localparam int FILL_W = $clog2(RING_FRAMES + 1);
    localparam int CMP_W  = (FILL_W > CNT_W) ? FILL_W : CNT_W;

    logic [1:0]          fmt_reg;
    logic                stereo_reg;
    logic [STEP_W-1:0]   step_reg;

    in_item_t            item_reg;
    logic signed [SAMPLE_W-1:0] left_reg;
    logic signed [SAMPLE_W-1:0] right_reg;

    logic [IDX_W-1:0]    wr_idx_reg;
    logic [IDX_W-1:0]    rd_idx_reg;
    logic [FILL_W-1:0]   fill_reg;
    logic [PHASE_W-1:0]  phase_reg;
    logic [DROP_W-1:0]   drop_reg;
    logic [CNT_W-1:0]    beats_reg;
    logic [CNT_W-1:0]    pad_reg;

    logic [2*SAMPLE_W-1:0] ring_mem [RING_FRAMES];
    logic [2*SAMPLE_W-1:0] rd_data_reg;

    logic                m_valid_reg;
    out_item_t           m_data_reg;

    logic signed [SAMPLE_W-1:0] left_dec;
    logic signed [SAMPLE_W-1:0] right_dec;
    logic [PHASE_W-1:0]  step_eff;
    logic [CNT_W-1:0]    want;
    logic [CMP_W-1:0]    want_ext;
    logic [CMP_W-1:0]    fill_ext;
    logic [CNT_W-1:0]    pad_calc;
    logic                ring_full;

    always_comb begin
        left_dec  = decode_word(item_reg.left_raw, fmt_reg);
        right_dec = stereo_reg ? decode_word(item_reg.right_raw, fmt_reg) : left_dec;
        if (item_reg.silent) begin
            left_dec  = '0;
            right_dec = '0;
        end
        step_eff  = (step_reg == '0) ? PHASE_W'(1) : PHASE_W'(step_reg);
        want      = (item_reg.read_count > CNT_W'(READ_MAX)) ? CNT_W'(READ_MAX)
                                                              : item_reg.read_count;
        want_ext  = CMP_W'(want);
        fill_ext  = CMP_W'(fill_reg);
        pad_calc  = (fill_ext < want_ext) ? CNT_W'(want_ext - fill_ext) : '0;
        ring_full = (fill_reg == FILL_W'(RING_FRAMES));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fmt_reg    <= FMT_FLOAT32;
            stereo_reg <= 1'b1;
            step_reg   <= STEP_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_SAMPLE_FORMAT: fmt_reg    <= cfg_wdata[1:0];
                CFG_STEREO_INPUT:  stereo_reg <= cfg_wdata[0];
                CFG_RATE_STEP:     step_reg   <= cfg_wdata[STEP_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            item_reg <= s_data;
        end
        if (cmd.decode) begin
            left_reg  <= left_dec;
            right_reg <= right_dec;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_idx_reg <= '0;
            rd_idx_reg <= '0;
            fill_reg   <= '0;
            phase_reg  <= '0;
            drop_reg   <= '0;
            beats_reg  <= '0;
            pad_reg    <= '0;
        end else begin
            if (cmd.write_frame) begin
                phase_reg  <= phase_reg + step_eff;
                wr_idx_reg <= (wr_idx_reg == IDX_W'(RING_FRAMES - 1)) ? '0 : wr_idx_reg + 1'b1;
                if (ring_full) begin
                    rd_idx_reg <= (rd_idx_reg == IDX_W'(RING_FRAMES - 1)) ? '0
                                                                          : rd_idx_reg + 1'b1;
                    if (drop_reg != DROP_MAX) begin
                        drop_reg <= drop_reg + 1'b1;
                    end
                end else begin
                    fill_reg <= fill_reg + 1'b1;
                end
            end
            if (cmd.phase_wrap) begin
                phase_reg <= phase_reg - PHASE_ONE;
            end
            if (cmd.rd_setup) begin
                beats_reg <= want;
                pad_reg   <= pad_calc;
            end
            if (cmd.emit_pad) begin
                beats_reg <= beats_reg - 1'b1;
                pad_reg   <= pad_reg - 1'b1;
            end
            if (cmd.rd_issue) begin
                rd_idx_reg <= (rd_idx_reg == IDX_W'(RING_FRAMES - 1)) ? '0 : rd_idx_reg + 1'b1;
                fill_reg   <= fill_reg - 1'b1;
            end
            if (cmd.rd_load) begin
                beats_reg <= beats_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.write_frame) begin
            ring_mem[wr_idx_reg] <= {left_reg, right_reg};
        end
        if (cmd.rd_issue) begin
            rd_data_reg <= ring_mem[rd_idx_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.emit_pad || cmd.rd_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit_pad) begin
            m_data_reg.left_sample  <= '0;
            m_data_reg.right_sample <= '0;
            m_data_reg.is_padding   <= 1'b1;
            m_data_reg.last         <= (beats_reg == CNT_W'(1));
            m_data_reg.drop_count   <= drop_reg;
        end else if (cmd.rd_load) begin
            m_data_reg.left_sample  <= rd_data_reg[2*SAMPLE_W-1:SAMPLE_W];
            m_data_reg.right_sample <= rd_data_reg[SAMPLE_W-1:0];
            m_data_reg.is_padding   <= 1'b0;
            m_data_reg.last         <= (beats_reg == CNT_W'(1));
            m_data_reg.drop_count   <= drop_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_comb begin
        sts.is_read     = (item_reg.kind == KIND_READ);
        sts.want_zero   = (want == '0);
        sts.phase_low   = (phase_reg < PHASE_ONE);
        sts.pad_pending = (pad_reg != '0);
        sts.beats_one   = (beats_reg == CNT_W'(1));
        sts.out_free    = !m_valid_reg || m_ready;
    end

endmodule
